/* rtl/core/tfs_pkg.sv */
// Shared types, opcodes and control store for the typed field serializer.
`default_nettype none

package tfs_pkg;

  // Field opcodes as carried on field_type
  typedef enum logic [2:0] {
    FT_BOOL    = 3'd0,
    FT_BYTE    = 3'd1,
    FT_SHORT   = 3'd2,
    FT_INT     = 3'd3,
    FT_LONG    = 3'd4,
    FT_VARINT  = 3'd5,
    FT_VARLONG = 3'd6
  } field_type_t;

  localparam int CapWidth   = 21;
  localparam int ValWidth   = 64;
  localparam int LenWidth   = 4;
  localparam int GroupBits  = 7;
  localparam int NumGroups  = 10;
  localparam logic [CapWidth-1:0] CapReset = {CapWidth{1'b1}};

  // Control store addresses
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_CHECK = 3'd1,
    ST_OVF   = 3'd2,
    ST_FIX   = 3'd3,
    ST_VAR   = 3'd4
  } step_t;

  // Jump conditions
  typedef enum logic [1:0] {
    CND_IN       = 2'd0,  // input word accepted
    CND_DISPATCH = 2'd1,  // multiway branch on opcode and capacity
    CND_OUT_FREE = 2'd2,  // output register can take a word
    CND_LAST     = 2'd3   // final byte loaded into the output register
  } cond_t;

  // One control word: datapath enables plus jump condition and target
  typedef struct packed {
    logic  take_in;
    logic  emit;
    logic  var_mode;
    logic  ovf;
    cond_t cond;
    step_t jmp;
  } uctrl_t;

  // Microprogram; a step whose condition is false holds its address
  function automatic uctrl_t ucode_rom(input step_t addr);
    uctrl_t w;
    w = '{take_in: 1'b0, emit: 1'b0, var_mode: 1'b0, ovf: 1'b0,
          cond: CND_IN, jmp: ST_IDLE};
    case (addr)
      ST_IDLE:  begin
        w.take_in = 1'b1;
        w.cond    = CND_IN;
        w.jmp     = ST_CHECK;
      end
      ST_CHECK: begin
        w.cond = CND_DISPATCH;
        w.jmp  = ST_IDLE;
      end
      ST_OVF:   begin
        w.ovf  = 1'b1;
        w.cond = CND_OUT_FREE;
        w.jmp  = ST_IDLE;
      end
      ST_FIX:   begin
        w.emit = 1'b1;
        w.cond = CND_LAST;
        w.jmp  = ST_IDLE;
      end
      ST_VAR:   begin
        w.emit     = 1'b1;
        w.var_mode = 1'b1;
        w.cond     = CND_LAST;
        w.jmp      = ST_IDLE;
      end
      default:  begin
        w.cond = CND_OUT_FREE;
        w.jmp  = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/typed_field_serializer_core.sv */
// Top level: typed field serializer with a microcoded byte sequencer.
`default_nettype none

// Takes one typed field word (bool, byte, short, int, long, varint, varlong)
// and emits its wire bytes one output word per byte: fixed types big-endian,
// varints as 7-bit groups, least significant first, bit 7 marking
// continuation. last_byte flags the final word of a field. A field that
// would push the packet byte count past packet_capacity (APB register at
// address 0) yields a single word with overflow set and nothing else;
// new_packet restarts the count. A field is accepted in ST_IDLE, checked and
// dispatched in ST_CHECK, then sent one byte per cycle out of the shift
// register while the output register is free; an overflow word comes from
// ST_OVF and an unused opcode returns to ST_IDLE. The sequencer accepts the
// next field while the final byte still waits in the output register.
module typed_field_serializer_core
  import tfs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // field input
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic [2:0]          field_type,
  input  wire logic [ValWidth-1:0] field_value,
  input  wire logic                new_packet,
  // byte output
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic [7:0]          out_byte,
  output      logic                last_byte,
  output      logic                overflow,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output      logic [31:0]         prdata,
  output      logic                pready
);

  step_t                step;
  uctrl_t               uc;
  logic [CapWidth-1:0]  packet_capacity;
  logic [CapWidth-1:0]  packet_count;
  logic [ValWidth-1:0]  shift_value;
  logic [LenWidth-1:0]  bytes_left;
  logic                 item_ok;
  logic                 item_var;

  logic [ValWidth-1:0]  load_value;
  logic [LenWidth-1:0]  load_len;
  logic                 load_ok;
  logic                 load_var;
  logic [ValWidth-1:0]  var_src;
  logic [NumGroups-1:0] grp_nz;
  logic [LenWidth-1:0]  grp_len;
  logic [CapWidth:0]    count_sum;
  logic                 no_fit;
  logic                 out_free;
  logic                 in_fire;
  logic                 cond_true;
  step_t                step_next;
  logic                 cfg_wr;

  // Control word for the current step
  assign uc       = ucode_rom(step);
  assign in_ready = uc.take_in;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Varint length: one more than the highest nonzero 7-bit group
  assign var_src = (field_type == FT_VARINT) ?
                   {32'd0, field_value[31:0]} : field_value;
  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_nz[g] = 1'b0;
      for (int b = 0; b < GroupBits; b++) begin
        if (g * GroupBits + b < ValWidth) begin
          grp_nz[g] = grp_nz[g] | var_src[g * GroupBits + b];
        end
      end
    end
    grp_len = LenWidth'(1);
    for (int g = 1; g < NumGroups; g++) begin
      if (grp_nz[g]) begin
        grp_len = LenWidth'(g + 1);
      end
    end
  end

  // Load decode: fixed types are left-justified for MSB-first shifting
  always_comb begin
    load_value = '0;
    load_len   = '0;
    load_ok    = 1'b1;
    load_var   = 1'b0;
    case (field_type)
      FT_BOOL:    begin
        load_value = {7'd0, (field_value[31:0] != 32'd0), 56'd0};
        load_len   = LenWidth'(1);
      end
      FT_BYTE:    begin
        load_value = {field_value[7:0], 56'd0};
        load_len   = LenWidth'(1);
      end
      FT_SHORT:   begin
        load_value = {field_value[15:0], 48'd0};
        load_len   = LenWidth'(2);
      end
      FT_INT:     begin
        load_value = {field_value[31:0], 32'd0};
        load_len   = LenWidth'(4);
      end
      FT_LONG:    begin
        load_value = field_value;
        load_len   = LenWidth'(8);
      end
      FT_VARINT, FT_VARLONG: begin
        load_value = var_src;
        load_len   = grp_len;
        load_var   = 1'b1;
      end
      default:    begin
        load_ok = 1'b0;
      end
    endcase
  end

  // Capacity check against the running count
  assign count_sum = {1'b0, packet_count} + {{(CapWidth + 1 - LenWidth){1'b0}}, bytes_left};
  assign no_fit    = count_sum > {1'b0, packet_capacity};

  // Sequencer: jump on condition, else hold
  always_comb begin
    cond_true = 1'b0;
    step_next = step;
    case (uc.cond)
      CND_IN:       cond_true = in_fire;
      CND_DISPATCH: cond_true = 1'b1;
      CND_OUT_FREE: cond_true = out_free;
      CND_LAST:     cond_true = out_free && (bytes_left == LenWidth'(1));
      default:      cond_true = 1'b0;
    endcase
    if (uc.cond == CND_DISPATCH) begin
      if (!item_ok) begin
        step_next = uc.jmp;
      end else if (no_fit) begin
        step_next = ST_OVF;
      end else if (item_var) begin
        step_next = ST_VAR;
      end else begin
        step_next = ST_FIX;
      end
    end else if (cond_true) begin
      step_next = uc.jmp;
    end
  end

  // APB register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - CapWidth){1'b0}}, packet_capacity} : 32'd0;

  // Datapath and sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      step            <= ST_IDLE;
      packet_capacity <= CapReset;
      packet_count    <= '0;
      bytes_left      <= '0;
      out_valid       <= 1'b0;
      item_ok         <= 1'b0;
      item_var        <= 1'b0;
    end else begin
      step <= step_next;
      if (cfg_wr) begin
        packet_capacity <= pwdata[CapWidth-1:0];
      end

      // accept: latch field, clear count on a new packet
      if (uc.take_in && in_valid) begin
        shift_value <= load_value;
        bytes_left  <= load_len;
        item_ok     <= load_ok;
        item_var    <= load_var;
        if (new_packet) begin
          packet_count <= '0;
        end
      end

      // dispatch: commit the byte count when the field fits
      if (uc.cond == CND_DISPATCH && item_ok && !no_fit) begin
        packet_count <= count_sum[CapWidth-1:0];
      end

      // output register
      if (uc.emit && out_free) begin
        out_valid <= 1'b1;
        overflow  <= 1'b0;
        last_byte <= (bytes_left == LenWidth'(1));
        if (uc.var_mode) begin
          out_byte    <= {(bytes_left != LenWidth'(1)), shift_value[6:0]};
          shift_value <= shift_value >> GroupBits;
        end else begin
          out_byte    <= shift_value[ValWidth-1 -: 8];
          shift_value <= shift_value << 8;
        end
        bytes_left <= bytes_left - LenWidth'(1);
      end else if (uc.ovf && out_free) begin
        out_valid <= 1'b1;
        out_byte  <= 8'd0;
        last_byte <= 1'b1;
        overflow  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // An accepted field always goes through the dispatch step next
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> step == ST_CHECK)
    else $error("accepted field did not reach dispatch");

  // Byte steps always have bytes pending
  a_emit_len: assert property (@(posedge clk) disable iff (rst)
    (step == ST_FIX || step == ST_VAR) |-> bytes_left != '0)
    else $error("byte step with no bytes left");

  // Overflow word is a lone, empty, final word
  a_ovf_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> last_byte && out_byte == 8'd0)
    else $error("malformed overflow word");

endmodule

`default_nettype wire
